>>> design/cv2d_pkg.sv
// Shared types, constants and helpers for the streaming 2D convolution block.
package cv2d_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Configuration port geometry: 64-bit registers at 8-byte spacing
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned PART_W   = 34;
  localparam int unsigned SUM_W    = 36;
  localparam int unsigned POS_W    = 10;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_ROWS  = 3'd2,
    REG_KERNEL_COLS  = 3'd3,
    REG_COEF_WORD0   = 3'd4,
    REG_COEF_WORD1   = 3'd5,
    REG_COEF_WORD2   = 3'd6
  } reg_idx_e;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd1024;
  localparam logic [1:0]  KERNEL_ROWS_RST  = 2'd3;
  localparam logic [1:0]  KERNEL_COLS_RST  = 2'd3;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [1:0]  kernel_rows;
    logic [1:0]  kernel_cols;
    logic [63:0] coef_word0;
    logic [63:0] coef_word1;
    logic [15:0] coef_word2;
  } cfg_t;

  // Coefficient for kernel slot m*3+n
  function automatic logic signed [COEF_W-1:0] coef_at(cfg_t cfg, int unsigned slot);
    logic signed [COEF_W-1:0] c;
    if (slot < 4) begin
      c = cfg.coef_word0[16*slot +: 16];
    end else if (slot < 8) begin
      c = cfg.coef_word1[16*(slot-4) +: 16];
    end else begin
      c = cfg.coef_word2;
    end
    return c;
  endfunction

endpackage

>>> design/cv2d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cv2d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/cv2d_regs.sv
// APB-style configuration register bank for the convolution block.
module cv2d_regs
  import cv2d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:3]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= IMAGE_WIDTH_RST;
      cfg_q.image_height <= IMAGE_HEIGHT_RST;
      cfg_q.kernel_rows  <= KERNEL_ROWS_RST;
      cfg_q.kernel_cols  <= KERNEL_COLS_RST;
      cfg_q.coef_word0   <= '0;
      cfg_q.coef_word1   <= '0;
      cfg_q.coef_word2   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[10:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[10:0];
        REG_KERNEL_ROWS:  cfg_q.kernel_rows  <= pwdata[1:0];
        REG_KERNEL_COLS:  cfg_q.kernel_cols  <= pwdata[1:0];
        REG_COEF_WORD0:   cfg_q.coef_word0   <= pwdata;
        REG_COEF_WORD1:   cfg_q.coef_word1   <= pwdata;
        REG_COEF_WORD2:   cfg_q.coef_word2   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(cfg_q.image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(cfg_q.image_height);
      REG_KERNEL_ROWS:  prdata = CFG_DATA_W'(cfg_q.kernel_rows);
      REG_KERNEL_COLS:  prdata = CFG_DATA_W'(cfg_q.kernel_cols);
      REG_COEF_WORD0:   prdata = cfg_q.coef_word0;
      REG_COEF_WORD1:   prdata = cfg_q.coef_word1;
      REG_COEF_WORD2:   prdata = CFG_DATA_W'(cfg_q.coef_word2);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/conv2d_valid_stream.sv
// Top level: streaming valid-mode cross-correlation, kernel up to 3x3, with line buffers.
// Samples enter in raster order on the input channel (in_valid_i/in_stall_o),
// one beat per sample; first_of_image_i restarts the position counters.
// Each sample whose window is complete yields one result beat on the output
// channel (out_valid_o/out_stall_i): the exact signed 36-bit window sum, its row and
// column in the valid result, and a last-of-image mark.
// Throughput: one sample per cycle while the skid register is empty. A result
// passes, in order, the line-store read, tap select, 9 multiplies and two adder
// levels. The two previous rows sit in one RAM, read and written once per
// sample; a same-column back-to-back access is forwarded around the RAM.
// Reset clears the counters, the pipeline valids and the registers to their
// defaults; the line store and window are not cleared and no clearing pass
// runs, so the block takes samples from the first cycle after reset.
// When the receiver stalls, the output register holds its beat and one more
// result lands in a skid register; in_stall_o then rises and the whole
// pipeline freezes until the skid register drains.
// Configuration is by an APB-style port, 64-bit registers at 8-byte spacing;
// the user must write it only while the block is idle; the block does not enforce this.
module conv2d_valid_stream
  import cv2d_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       first_of_image_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SUM_W-1:0]    conv_sum_o,
  output logic [POS_W-1:0]           out_row_o,
  output logic [POS_W-1:0]           out_col_o,
  output logic                       last_of_image_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_W-1:0]      paddr,
  input  logic [CFG_DATA_W-1:0]      pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LW = 2 * SAMPLE_W;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } meta_t;

  cfg_t cfg;

  cv2d_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Limits from configuration
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [1:0]    krm1, kcm1, krc, kcc;

  always_comb begin
    if (cfg.image_width == '0) begin
      wm1 = '0;
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(cfg.image_width - 11'd1);
    end
    if (cfg.image_height == '0) begin
      hm1 = '0;
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(cfg.image_height - 11'd1);
    end
    krm1 = (cfg.kernel_rows == '0) ? 2'd0 : cfg.kernel_rows - 2'd1;
    kcm1 = (cfg.kernel_cols == '0) ? 2'd0 : cfg.kernel_cols - 2'd1;
    // offset of the kernel's first tap inside the 3x3 window
    krc  = 2'd2 - krm1;
    kcc  = 2'd2 - kcm1;
  end

  // ---------------------------------------------------------------------------
  // Flow control: the pipeline moves whenever the skid register is empty
  logic skid_valid_q;
  logic adv;
  logic accept;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Position counters and accept stage
  logic [RW-1:0] row_q, row_d, row_cur;
  logic [CW-1:0] col_q, col_d, col_cur;
  logic          row_end, img_end, produce;
  meta_t         meta_in;

  always_comb begin
    row_cur = first_of_image_i ? '0 : row_q;
    col_cur = first_of_image_i ? '0 : col_q;
    row_end = col_cur >= wm1;
    img_end = row_end && (row_cur >= hm1);
    produce = (row_cur >= RW'(krm1)) && (col_cur >= CW'(kcm1));
    meta_in.row  = POS_W'(row_cur - RW'(krm1));
    meta_in.col  = POS_W'(col_cur - CW'(kcm1));
    meta_in.last = img_end;
    if (img_end) begin
      row_d = '0;
      col_d = '0;
    end else if (row_end) begin
      row_d = row_cur + RW'(1);
      col_d = '0;
    end else begin
      row_d = row_cur;
      col_d = col_cur + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line-store read data, forwarding, window shift
  logic                       s1_valid_q, s1_prod_q, s1_fwd_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q, s1_ftop_q, s1_fmid_q;
  logic [CW-1:0]              s1_addr_q;
  meta_t                      s1_meta_q;
  logic [LW-1:0]              ram_rdata;
  logic signed [SAMPLE_W-1:0] s1_top, s1_mid;

  // RAM word: upper half is two rows back, lower half is the previous row
  cv2d_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && adv),
    .waddr_i (s1_addr_q),
    .wdata_i ({s1_mid, s1_sample_q}),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  assign s1_top = s1_fwd_q ? s1_ftop_q : ram_rdata[LW-1:SAMPLE_W];
  assign s1_mid = s1_fwd_q ? s1_fmid_q : ram_rdata[SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_addr_q   <= col_cur;
      s1_prod_q   <= produce;
      s1_meta_q   <= meta_in;
      // the beat ahead writes this column at the same edge as our read
      s1_fwd_q    <= s1_valid_q && (s1_addr_q == col_cur);
      s1_ftop_q   <= s1_mid;
      s1_fmid_q   <= s1_sample_q;
    end
  end

  logic signed [SAMPLE_W-1:0] win_q  [3][3];
  logic signed [SAMPLE_W-1:0] win_d  [3][3];
  logic signed [SAMPLE_W-1:0] tap_d  [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      win_d[a][0] = win_q[a][1];
      win_d[a][1] = win_q[a][2];
    end
    win_d[0][2] = s1_top;
    win_d[1][2] = s1_mid;
    win_d[2][2] = s1_sample_q;
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        if ((2'(m) <= krm1) && (2'(n) <= kcm1)) begin
          tap_d[m][n] = win_d[2'(m) + krc][2'(n) + kcc];
        end else begin
          tap_d[m][n] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: selected taps; stage 3: products; stage 4: row partial sums
  logic                       s2_valid_q, s3_valid_q, s4_valid_q;
  logic signed [SAMPLE_W-1:0] s2_tap_q  [3][3];
  logic signed [PROD_W-1:0]   s3_prod_q [3][3];
  logic signed [PART_W-1:0]   s4_part_q [3];
  meta_t                      s2_meta_q, s3_meta_q, s4_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_prod_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_tap_q  <= tap_d;
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
      s4_meta_q <= s3_meta_q;
    end
  end

  for (genvar gm = 0; gm < 3; gm++) begin : g_row
    for (genvar gn = 0; gn < 3; gn++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (adv) begin
          s3_prod_q[gm][gn] <= s2_tap_q[gm][gn] * coef_at(cfg, gm * 3 + gn);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s4_part_q[gm] <= PART_W'(s3_prod_q[gm][0]) + PART_W'(s3_prod_q[gm][1])
                       + PART_W'(s3_prod_q[gm][2]);
      end
    end
  end

  logic signed [SUM_W-1:0] sum;
  logic                    push;

  assign sum  = SUM_W'(s4_part_q[0]) + SUM_W'(s4_part_q[1]) + SUM_W'(s4_part_q[2]);
  assign push = adv && s4_valid_q;

  // ---------------------------------------------------------------------------
  // Output register and skid register
  logic                    out_valid_q;
  logic signed [SUM_W-1:0] out_sum_q, skid_sum_q;
  meta_t                   out_meta_q, skid_meta_q;
  logic                    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_sum_q  <= skid_sum_q;
        out_meta_q <= skid_meta_q;
      end else if (push) begin
        out_sum_q  <= sum;
        out_meta_q <= s4_meta_q;
      end
    end else if (push) begin
      skid_sum_q  <= sum;
      skid_meta_q <= s4_meta_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign conv_sum_o      = out_sum_q;
  assign out_row_o       = out_meta_q.row;
  assign out_col_o       = out_meta_q.col;
  assign last_of_image_o = out_meta_q.last;

  // ---------------------------------------------------------------------------
  // Assertions
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  a_push_into_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && !skid_valid_q && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("result reaching a stalled output was not caught by the skid register");

  a_frozen_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> ($stable(s4_valid_q) && $stable(row_q) && $stable(col_q)))
    else $error("pipeline or counters moved while the skid register was full");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the streaming valid-mode 2D convolution block.
`timescale 1ns / 1ps

module tb_top;
  import cv2d_pkg::*;

  localparam int unsigned HOLD_CYCLES     = 100;
  localparam int unsigned HOLD_SPACING    = 1500;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS    = 760;
  localparam int unsigned RESET_ROW_ITEMS = 40;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

  typedef struct {
    logic signed [15:0] px;
    logic               sof;
  } pixel_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    eoi;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       first_of_image_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SUM_W-1:0]    conv_sum_o;
  logic [POS_W-1:0]           out_row_o;
  logic [POS_W-1:0]           out_col_o;
  logic                       last_of_image_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  conv2d_valid_stream dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .first_of_image_i(first_of_image_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .conv_sum_o      (conv_sum_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_of_image_o (last_of_image_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #1 clk_i = ~clk_i;

  pixel_t       pixels_to_send[$];
  conv_result_t window_sums_due[$];
  int unsigned  fail_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  random_items = 0;

  // Predictor state: register copy, the two previous rows, the 3x3 window, position
  cfg_t               cfg_shadow;
  bit signed [15:0]   line_hist [2][MAX_WIDTH_DEF];
  bit signed [15:0]   taps [3][3];
  int unsigned        row_pos = 0;
  int unsigned        col_pos = 0;

  function automatic int unsigned limit_dim(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [15:0] coef_of(int unsigned slot);
    logic [143:0] all_coefs;
    all_coefs = {cfg_shadow.coef_word2, cfg_shadow.coef_word1, cfg_shadow.coef_word0};
    return all_coefs[16*slot +: 16];
  endfunction

  task automatic convolve_pixel(input logic signed [15:0] s, input logic head);
    int unsigned w, h, kr, kc, r, c, ci, a, m, n;
    logic signed [15:0] top, mid;
    logic signed [63:0] acc;
    logic row_end, img_end;
    conv_result_t res;
    w  = limit_dim(cfg_shadow.image_width, MAX_WIDTH_DEF);
    h  = limit_dim(cfg_shadow.image_height, MAX_HEIGHT_DEF);
    kr = limit_dim(cfg_shadow.kernel_rows, 3);
    kc = limit_dim(cfg_shadow.kernel_cols, 3);
    if (head) begin
      row_pos = 0;
      col_pos = 0;
    end
    r  = row_pos;
    c  = col_pos;
    ci = (c < MAX_WIDTH_DEF) ? c : MAX_WIDTH_DEF - 1;
    top = line_hist[1][ci];
    mid = line_hist[0][ci];
    line_hist[1][ci] = mid;
    line_hist[0][ci] = s;
    for (a = 0; a < 3; a++) begin
      taps[a][0] = taps[a][1];
      taps[a][1] = taps[a][2];
    end
    taps[0][2] = top;
    taps[1][2] = mid;
    taps[2][2] = s;
    row_end = (c >= w - 1);
    img_end = row_end && (r >= h - 1);
    if (r >= kr - 1 && c >= kc - 1) begin
      acc = '0;
      for (m = 0; m < kr; m++) begin
        for (n = 0; n < kc; n++) begin
          acc = acc + taps[3-kr+m][3-kc+n] * coef_of(m*3 + n);
        end
      end
      res.sum = acc[SUM_W-1:0];
      res.row = POS_W'(r - (kr - 1));
      res.col = POS_W'(c - (kc - 1));
      res.eoi = img_end;
      window_sums_due.insert(window_sums_due.size(), res);
    end
    if (img_end) begin
      row_pos = 0;
      col_pos = 0;
    end else if (row_end) begin
      row_pos = r + 1;
      col_pos = 0;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // Sender: one beat per item, a drawn gap after each accepted beat
  int unsigned send_wait = 0;
  bit          send_burst = 1'b0;
  pixel_t      next_pix;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      sample_i         <= '0;
      first_of_image_i <= 1'b0;
      send_wait        <= 0;
      send_burst       <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) convolve_pixel(sample_i, first_of_image_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait != 0) begin
          in_valid_i <= 1'b0;
          send_wait  <= send_wait - 1;
        end else if (pixels_to_send.size() != 0) begin
          next_pix = pixels_to_send.pop_front();
          in_valid_i       <= 1'b1;
          sample_i         <= next_pix.px;
          first_of_image_i <= next_pix.sof;
          send_wait        <= send_burst ? 0 : $urandom_range(0, 6);
          if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: drawn stall after each beat, plus long hold-offs to fill the block
  int unsigned recv_wait = 0;
  int unsigned recv_draw;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 400;
  bit          recv_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      recv_wait    <= 0;
      hold_left    <= 0;
      next_hold_at <= 400;
      recv_burst   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (results_seen >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
      out_stall_i  <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      recv_draw = recv_burst ? 0 : $urandom_range(0, 6);
      recv_wait   <= recv_draw;
      out_stall_i <= (recv_draw != 0);
      if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
    end else if (recv_wait != 0) begin
      recv_wait   <= recv_wait - 1;
      out_stall_i <= (recv_wait > 1);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  conv_result_t due;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (window_sums_due.size() == 0) begin
        report_mismatch($sformatf("result beat (%0d,%0d) with no sample behind it",
                                  out_row_o, out_col_o));
      end else begin
        due = window_sums_due.pop_front();
        if (conv_sum_o !== due.sum)
          report_mismatch($sformatf("conv_sum at (%0d,%0d): got %0d want %0d",
                                    due.row, due.col, conv_sum_o, due.sum));
        if (out_row_o !== due.row)
          report_mismatch($sformatf("out_row: got %0d want %0d", out_row_o, due.row));
        if (out_col_o !== due.col)
          report_mismatch($sformatf("out_col: got %0d want %0d", out_col_o, due.col));
        if (last_of_image_o !== due.eoi)
          report_mismatch($sformatf("last_of_image at (%0d,%0d): got %b want %b",
                                    due.row, due.col, last_of_image_o, due.eoi));
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("conv2d_valid_stream regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] wdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  cfg_shadow.image_width  = wdata[10:0];
      REG_IMAGE_HEIGHT: cfg_shadow.image_height = wdata[10:0];
      REG_KERNEL_ROWS:  cfg_shadow.kernel_rows  = wdata[1:0];
      REG_KERNEL_COLS:  cfg_shadow.kernel_cols  = wdata[1:0];
      REG_COEF_WORD0:   cfg_shadow.coef_word0   = wdata;
      REG_COEF_WORD1:   cfg_shadow.coef_word1   = wdata;
      REG_COEF_WORD2:   cfg_shadow.coef_word2   = wdata[15:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned kr, input int unsigned kc);
    cfg_write(REG_IMAGE_WIDTH, 64'(w));
    cfg_write(REG_IMAGE_HEIGHT, 64'(h));
    cfg_write(REG_KERNEL_ROWS, 64'(kr));
    cfg_write(REG_KERNEL_COLS, 64'(kc));
  endtask

  task automatic set_coefs(input logic [63:0] c0, input logic [63:0] c1,
                           input logic [15:0] c2);
    cfg_write(REG_COEF_WORD0, c0);
    cfg_write(REG_COEF_WORD1, c1);
    cfg_write(REG_COEF_WORD2, 64'(c2));
  endtask

  task automatic push_pixel(input logic signed [15:0] s, input logic head);
    pixel_t pix;
    pix.px  = s;
    pix.sof = head;
    pixels_to_send.insert(pixels_to_send.size(), pix);
  endtask

  function automatic logic signed [15:0] draw_sample();
    case ($urandom_range(0, 15))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      3:       return '1;
      default: return 16'($urandom());
    endcase
  endfunction

  // Idle point: everything sent, every result back, then room for beats that give none
  task automatic drain_block();
    do @(negedge clk_i);
    while (pixels_to_send.size() != 0 || in_valid_i || window_sums_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase();
    int unsigned w, h, full, len, n_img, img, style, k, cut_at;
    logic        noisy;
    logic [15:0] pat;
    case ($urandom_range(0, 19))
      0:       w = 0;
      1:       w = $urandom_range(1025, 2047);
      2:       w = MAX_WIDTH_DEF;
      3, 4, 5: w = $urandom_range(17, 40);
      default: w = $urandom_range(1, 16);
    endcase
    case ($urandom_range(0, 19))
      0:       h = 0;
      1:       h = $urandom_range(1025, 2047);
      2:       h = MAX_HEIGHT_DEF;
      default: h = $urandom_range(1, 10);
    endcase
    set_geometry(w, h, $urandom_range(0, 3), $urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0) begin
      pat = $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
      set_coefs({4{pat}}, {4{pat}}, pat);
    end else begin
      set_coefs({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()));
    end
    full  = limit_dim(w, MAX_WIDTH_DEF) * limit_dim(h, MAX_HEIGHT_DEF);
    n_img = $urandom_range(1, 3);
    for (img = 0; img < n_img; img++) begin
      style  = $urandom_range(0, 9);
      len    = (full <= 300) ? full : $urandom_range(20, 120);
      cut_at = 0;
      noisy  = 1'b0;
      case (style)
        6: noisy = 1'b1;                              // stray start flags
        7: len = $urandom_range(1, len);              // image cut short
        8: cut_at = $urandom_range(1, len);           // restart partway through
        9: cut_at = len;                              // no flag, counters must wrap
        default: ;
      endcase
      // the geometry has just changed, so the first image of a phase starts flagged
      for (k = 0; k < len; k++)
        push_pixel(draw_sample(),
                   (k == cut_at) || (img == 0 && k == 0) ||
                   (noisy && $urandom_range(0, 7) == 0));
      random_items += len;
    end
    drain_block();
  endtask

  initial begin
    int unsigned k;
    cfg_shadow = '{image_width: IMAGE_WIDTH_RST, image_height: IMAGE_HEIGHT_RST,
                   kernel_rows: KERNEL_ROWS_RST, kernel_cols: KERNEL_COLS_RST,
                   coef_word0: '0, coef_word1: '0, coef_word2: '0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: a short first row gives no result under the 3x3 kernel
    set_coefs({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()));
    for (k = 0; k < RESET_ROW_ITEMS; k++) push_pixel(draw_sample(), k == 0);
    drain_block();

    // Largest magnitudes; second image follows without a start flag
    set_geometry(3, 3, 3, 3);
    set_coefs({4{SAMPLE_MIN}}, {4{SAMPLE_MIN}}, SAMPLE_MIN);
    for (k = 0; k < 9; k++) push_pixel(SAMPLE_MIN, k == 0);
    for (k = 0; k < 9; k++) push_pixel(SAMPLE_MAX, 1'b0);
    drain_block();

    // Zero sizes read as one, oversize height saturates, stray register write ignored
    set_geometry(0, 2047, 0, 0);
    set_coefs({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()));
    cfg_write(REG_UNUSED, {$urandom(), $urandom()});
    for (k = 0; k < 6; k++) push_pixel(draw_sample(), k == 0 || k == 4);
    drain_block();

    // Kernel bigger than the image: nothing comes out
    set_geometry(2, 2, 3, 3);
    for (k = 0; k < 5; k++) push_pixel(draw_sample(), k == 0);
    drain_block();

    // Single column at full height
    set_geometry(1, MAX_HEIGHT_DEF, 3, 1);
    set_coefs({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'($urandom()));
    for (k = 0; k < MAX_HEIGHT_DEF; k++) push_pixel(draw_sample(), k == 0);
    drain_block();

    while (random_items < RANDOM_ITEMS) random_phase();

    if (window_sums_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", window_sums_due.size()));
    if (fail_count == 0) begin
      $display("conv2d_valid_stream regression: pass");
    end else begin
      $display("conv2d_valid_stream regression: fail");
    end
    $finish;
  end

endmodule
